[sv/bvhms_pkg.sv]
package bvhms_pkg;

  localparam int MAX_PRIMS   = 1024;
  localparam int PRIM_AW     = 10;
  localparam int NODE_DEPTH  = 2048;
  localparam int NODE_AW     = 11;
  localparam int STACK_DEPTH = 128;
  localparam int STACK_AW    = 7;
  localparam int SP_W        = 8;
  localparam int CNT_W       = 11;

  localparam logic [CNT_W-1:0] PRIM_LIMIT = 11'd1024;
  localparam logic [CNT_W-1:0] NODE_LIMIT = 11'd2047;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_NODE = 2'd1;
  localparam logic [1:0] REQ_PRIM = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FAIL  = 2'd2;

  localparam logic [10:0] LEAF_SIZE_RESET = 11'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [10:0]        read_index;
    logic               last_prim;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic signed [31:0] cent_x;
    logic signed [31:0] cent_y;
    logic signed [31:0] cent_z;
  } req_t;

  typedef struct packed {
    logic [9:0]         first_prim;
    logic [10:0]        prim_count;
    logic [10:0]        right_offset;
    logic signed [31:0] node_min_x;
    logic signed [31:0] node_min_y;
    logic signed [31:0] node_min_z;
    logic signed [31:0] node_max_x;
    logic signed [31:0] node_max_y;
    logic signed [31:0] node_max_z;
    logic [9:0]         prim_id;
    logic [10:0]        total_nodes;
    logic [1:0]         status;
  } res_t;

  // Box entries 0..2 are the minimum x/y/z, 3..5 the maximum.
  typedef struct packed {
    logic [2:0][31:0] cent;
    logic [5:0][31:0] box;
  } prim_rec_t;

  typedef struct packed {
    logic [9:0]       start;
    logic [10:0]      size;
    logic [5:0][31:0] box;
  } node_rec_t;

  typedef struct packed {
    logic [10:0] lo;
    logic [10:0] hi;
    logic [10:0] parent;
    logic        has_parent;
  } stk_rec_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_ROOT, S_POP, S_POPW, S_SA, S_SB, S_SC, S_NODE, S_PAR,
    S_AXIS, S_PA, S_PB, S_PC, S_PD, S_PE, S_SPLIT, S_PUSHR, S_PUSHL, S_RD, S_RDW
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_INIT, OP_ROOT, OP_POP, OP_BEGIN, OP_SCAN_A,
    OP_SCAN_B, OP_SCAN_C, OP_NODE, OP_PAR, OP_AXIS, OP_PART_A, OP_PART_B,
    OP_PART_C, OP_NEXTK, OP_SWAP1, OP_SWAP2, OP_FIXMID, OP_PUSHR, OP_PUSHL,
    OP_FIN_OK, OP_FIN_FAIL, OP_RDADDR, OP_RDOUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_build;
    logic in_read;
    logic init_last;
    logic pop_empty;
    logic pop_bad;
    logic scan_last;
    logic need_par;
    logic is_leaf;
    logic go_left;
    logic push_fail;
  } sts_t;

endpackage

[sv/bvhms_ram.sv]
module bvhms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/bvhms_ctrl.sv]
module bvhms_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bvhms_pkg::sts_t sts,
  output bvhms_pkg::cmd_t cmd,
  output logic            busy
);
  import bvhms_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && sts.in_build) state_next = S_INIT;
        else if (start && sts.in_read) state_next = S_RD;
      end
      S_INIT:  if (sts.init_last) state_next = S_ROOT;
      S_ROOT:  state_next = S_SA;
      S_POP:   state_next = sts.pop_empty ? S_IDLE : S_POPW;
      S_POPW:  state_next = sts.pop_bad ? S_IDLE : S_SA;
      S_SA:    state_next = S_SB;
      S_SB:    state_next = S_SC;
      S_SC:    state_next = sts.scan_last ? S_NODE : S_SA;
      S_NODE: begin
        if (sts.need_par) state_next = S_PAR;
        else state_next = sts.is_leaf ? S_POP : S_AXIS;
      end
      S_PAR:   state_next = sts.is_leaf ? S_POP : S_AXIS;
      S_AXIS:  state_next = S_PA;
      S_PA:    state_next = S_PB;
      S_PB:    state_next = S_PC;
      S_PC: begin
        if (sts.go_left) state_next = S_PD;
        else state_next = sts.scan_last ? S_SPLIT : S_PA;
      end
      S_PD:    state_next = S_PE;
      S_PE:    state_next = sts.scan_last ? S_SPLIT : S_PA;
      S_SPLIT: state_next = sts.push_fail ? S_IDLE : S_PUSHR;
      S_PUSHR: state_next = S_PUSHL;
      S_PUSHL: state_next = S_POP;
      S_RD:    state_next = S_RDW;
      S_RDW:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    case (state)
      S_IDLE:  if (start) cmd.op = OP_ACCEPT;
      S_INIT:  cmd.op = OP_INIT;
      S_ROOT:  cmd.op = OP_ROOT;
      S_POP:   cmd.op = sts.pop_empty ? OP_FIN_OK : OP_POP;
      S_POPW:  cmd.op = sts.pop_bad ? OP_FIN_FAIL : OP_BEGIN;
      S_SA:    cmd.op = OP_SCAN_A;
      S_SB:    cmd.op = OP_SCAN_B;
      S_SC:    cmd.op = OP_SCAN_C;
      S_NODE:  cmd.op = OP_NODE;
      S_PAR:   cmd.op = OP_PAR;
      S_AXIS:  cmd.op = OP_AXIS;
      S_PA:    cmd.op = OP_PART_A;
      S_PB:    cmd.op = OP_PART_B;
      S_PC: begin
        if (sts.go_left) cmd.op = OP_PART_C;
        else if (!sts.scan_last) cmd.op = OP_NEXTK;
      end
      S_PD:    cmd.op = OP_SWAP1;
      S_PE:    cmd.op = OP_SWAP2;
      S_SPLIT: cmd.op = sts.push_fail ? OP_FIN_FAIL : OP_FIXMID;
      S_PUSHR: cmd.op = OP_PUSHR;
      S_PUSHL: cmd.op = OP_PUSHL;
      S_RD:    cmd.op = OP_RDADDR;
      S_RDW:   cmd.op = OP_RDOUT;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[sv/bvhms_datapath.sv]
module bvhms_datapath (
  input  logic            clk,
  input  logic            rst,
  input  bvhms_pkg::req_t request,
  input  logic [10:0]     leaf_size,
  input  bvhms_pkg::cmd_t cmd,
  output bvhms_pkg::sts_t sts,
  output logic            result_valid,
  output bvhms_pkg::res_t result
);
  import bvhms_pkg::*;

  logic [CNT_W-1:0] loaded_count, built, lo, hi, parent, idx, pos, mid;
  logic             has_parent, build_done, overflow;
  logic [SP_W-1:0]  sp;
  req_t             rq;
  logic [9:0]       pcur;
  logic [1:0]       axis;
  logic signed [32:0] sum;
  logic signed [31:0] bb [0:5];
  logic signed [31:0] cb [0:5];
  res_t             result_next;

  logic                ord_we;
  logic [PRIM_AW-1:0]  ord_waddr, ord_raddr;
  logic [9:0]          ord_wdata, ord_rdata;
  logic                prim_we;
  logic [PRIM_AW-1:0]  prim_waddr;
  prim_rec_t           prim_wdata, prim_rdata;
  logic                node_we;
  node_rec_t           node_wdata, node_rdata;
  logic                offs_we;
  logic [NODE_AW-1:0]  offs_waddr;
  logic [10:0]         offs_wdata, offs_rdata;
  logic                stk_we;
  logic [STACK_AW-1:0] stk_waddr, stk_raddr;
  stk_rec_t            stk_wdata, stk_rdata;

  logic             is_load, load_room;
  logic [CNT_W-1:0] load_base, cnt, lim;
  logic signed [32:0] ext [0:2];
  logic [1:0]       axis_sel;
  logic signed [31:0] csel;

  assign is_load   = (request.req_type == REQ_LOAD);
  assign load_base = build_done ? '0 : loaded_count;
  assign load_room = (load_base < PRIM_LIMIT);
  assign cnt       = hi - lo;
  assign lim       = (leaf_size == '0) ? 11'd1 : leaf_size;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ext[a] = 33'(cb[3+a]) - 33'(cb[a]);
    end
    if (ext[0] >= ext[1] && ext[0] >= ext[2]) axis_sel = 2'd0;
    else if (ext[1] >= ext[2]) axis_sel = 2'd1;
    else axis_sel = 2'd2;
    case (axis)
      2'd0:    csel = $signed(prim_rdata.cent[0]);
      2'd1:    csel = $signed(prim_rdata.cent[1]);
      default: csel = $signed(prim_rdata.cent[2]);
    endcase
  end

  always_comb begin
    sts.in_build  = is_load && request.last_prim;
    sts.in_read   = (request.req_type == REQ_NODE) || (request.req_type == REQ_PRIM);
    sts.init_last = (pos == loaded_count - 11'd1);
    sts.pop_empty = (sp == '0);
    sts.pop_bad   = (built >= NODE_LIMIT) || (stk_rdata.lo >= stk_rdata.hi) ||
                    (stk_rdata.hi > loaded_count);
    sts.scan_last = (pos + 11'd1 == hi);
    sts.need_par  = has_parent && (idx != parent + 11'd1);
    sts.is_leaf   = (cnt <= lim);
    sts.go_left   = ($signed({csel, 1'b0}) < sum);
    sts.push_fail = ({1'b0, sp} + 9'd2) > 9'(STACK_DEPTH);
  end

  // Memory port steering.
  always_comb begin
    prim_we    = (cmd.op == OP_ACCEPT) && is_load && load_room;
    prim_waddr = load_base[PRIM_AW-1:0];
    prim_wdata.box[0]  = request.box_min_x;
    prim_wdata.box[1]  = request.box_min_y;
    prim_wdata.box[2]  = request.box_min_z;
    prim_wdata.box[3]  = request.box_max_x;
    prim_wdata.box[4]  = request.box_max_y;
    prim_wdata.box[5]  = request.box_max_z;
    prim_wdata.cent[0] = request.cent_x;
    prim_wdata.cent[1] = request.cent_y;
    prim_wdata.cent[2] = request.cent_z;

    ord_we    = 1'b0;
    ord_waddr = pos[PRIM_AW-1:0];
    ord_wdata = pos[9:0];
    case (cmd.op)
      OP_PART_C: ord_raddr = mid[PRIM_AW-1:0];
      OP_RDADDR: ord_raddr = rq.read_index[PRIM_AW-1:0];
      default:   ord_raddr = pos[PRIM_AW-1:0];
    endcase
    case (cmd.op)
      OP_INIT:  ord_we = 1'b1;
      OP_SWAP1: begin
        ord_we    = 1'b1;
        ord_wdata = ord_rdata;
      end
      OP_SWAP2: begin
        ord_we    = 1'b1;
        ord_waddr = mid[PRIM_AW-1:0];
        ord_wdata = pcur;
      end
      default: ord_we = 1'b0;
    endcase

    node_we          = (cmd.op == OP_NODE);
    node_wdata.start = lo[9:0];
    node_wdata.size  = cnt;
    for (int a = 0; a < 6; a++) begin
      node_wdata.box[a] = bb[a];
    end

    offs_we    = (cmd.op == OP_NODE) || (cmd.op == OP_PAR);
    offs_waddr = (cmd.op == OP_PAR) ? parent : idx;
    offs_wdata = (cmd.op == OP_PAR) ? (idx - parent) : '0;

    stk_raddr = STACK_AW'(sp - 8'd1);
    stk_waddr = sp[STACK_AW-1:0];
    stk_we    = (cmd.op == OP_PUSHR) || (cmd.op == OP_PUSHL);
    stk_wdata.parent     = idx;
    stk_wdata.has_parent = 1'b1;
    stk_wdata.lo = (cmd.op == OP_PUSHR) ? mid : lo;
    stk_wdata.hi = (cmd.op == OP_PUSHR) ? hi : mid;
  end

  // Result item for the end of a build or a read.
  always_comb begin
    result_next             = '0;
    result_next.total_nodes = built;
    case (cmd.op)
      OP_FIN_OK: result_next.status = overflow ? STAT_FAIL : STAT_OK;
      OP_FIN_FAIL: begin
        result_next.total_nodes = '0;
        result_next.status      = STAT_FAIL;
      end
      OP_RDOUT: begin
        if (!build_done) begin
          result_next.status = STAT_FAIL;
        end else if (rq.req_type == REQ_NODE) begin
          if (rq.read_index >= built) begin
            result_next.status = STAT_RANGE;
          end else begin
            result_next.first_prim   = node_rdata.start;
            result_next.prim_count   = node_rdata.size;
            result_next.right_offset = offs_rdata;
            result_next.node_min_x   = node_rdata.box[0];
            result_next.node_min_y   = node_rdata.box[1];
            result_next.node_min_z   = node_rdata.box[2];
            result_next.node_max_x   = node_rdata.box[3];
            result_next.node_max_y   = node_rdata.box[4];
            result_next.node_max_z   = node_rdata.box[5];
          end
        end else if (rq.read_index >= loaded_count) begin
          result_next.status = STAT_RANGE;
        end else begin
          result_next.prim_id = ord_rdata;
        end
      end
      default: result_next.status = STAT_OK;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      built        <= '0;
      build_done   <= 1'b0;
      overflow     <= 1'b0;
      sp           <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op inside {OP_FIN_OK, OP_FIN_FAIL, OP_RDOUT});
      case (cmd.op)
        OP_ACCEPT: begin
          sp <= '0;
          if (is_load) begin
            build_done <= 1'b0;
            if (build_done) built <= '0;
            overflow <= (build_done ? 1'b0 : overflow) | !load_room;
            if (load_room) loaded_count <= load_base + 11'd1;
            else loaded_count <= load_base;
          end
        end
        OP_ROOT:     built <= 11'd1;
        OP_POP:      sp <= sp - 8'd1;
        OP_BEGIN:    built <= built + 11'd1;
        OP_PUSHR,
        OP_PUSHL:    sp <= sp + 8'd1;
        OP_FIN_OK:   build_done <= 1'b1;
        OP_FIN_FAIL: begin
          build_done <= 1'b0;
          built      <= '0;
        end
        default:     sp <= sp;
      endcase
    end
  end

  // Working registers and the result.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        rq  <= request;
        pos <= '0;
      end
      OP_INIT: pos <= pos + 11'd1;
      OP_ROOT: begin
        lo         <= '0;
        hi         <= loaded_count;
        parent     <= '0;
        has_parent <= 1'b0;
        idx        <= '0;
        pos        <= '0;
      end
      OP_BEGIN: begin
        lo         <= stk_rdata.lo;
        hi         <= stk_rdata.hi;
        parent     <= stk_rdata.parent;
        has_parent <= stk_rdata.has_parent;
        idx        <= built;
        pos        <= stk_rdata.lo;
      end
      OP_SCAN_C: begin
        for (int a = 0; a < 3; a++) begin
          if (pos == lo || $signed(prim_rdata.box[a]) < bb[a]) begin
            bb[a] <= $signed(prim_rdata.box[a]);
          end
          if (pos == lo || $signed(prim_rdata.box[3+a]) > bb[3+a]) begin
            bb[3+a] <= $signed(prim_rdata.box[3+a]);
          end
          if (pos == lo || $signed(prim_rdata.cent[a]) < cb[a]) begin
            cb[a] <= $signed(prim_rdata.cent[a]);
          end
          if (pos == lo || $signed(prim_rdata.cent[a]) > cb[3+a]) begin
            cb[3+a] <= $signed(prim_rdata.cent[a]);
          end
        end
        pos <= pos + 11'd1;
      end
      OP_AXIS: begin
        axis <= axis_sel;
        case (axis_sel)
          2'd0:    sum <= 33'(cb[0]) + 33'(cb[3]);
          2'd1:    sum <= 33'(cb[1]) + 33'(cb[4]);
          default: sum <= 33'(cb[2]) + 33'(cb[5]);
        endcase
        pos <= lo;
        mid <= lo;
      end
      OP_PART_B: pcur <= ord_rdata;
      OP_NEXTK:  pos <= pos + 11'd1;
      OP_SWAP2: begin
        pos <= pos + 11'd1;
        mid <= mid + 11'd1;
      end
      OP_FIXMID: begin
        if (mid == lo || mid == hi) mid <= lo + (cnt >> 1);
      end
      OP_FIN_OK,
      OP_FIN_FAIL,
      OP_RDOUT: result <= result_next;
      default: pos <= pos;
    endcase
  end

  bvhms_ram #(.WIDTH($bits(prim_rec_t)), .DEPTH(MAX_PRIMS)) u_prim_ram (
    .clk(clk), .we(prim_we), .waddr(prim_waddr), .wdata(prim_wdata),
    .raddr(ord_rdata), .rdata(prim_rdata)
  );

  bvhms_ram #(.WIDTH(10), .DEPTH(MAX_PRIMS)) u_order_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  bvhms_ram #(.WIDTH($bits(node_rec_t)), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(idx), .wdata(node_wdata),
    .raddr(rq.read_index), .rdata(node_rdata)
  );

  bvhms_ram #(.WIDTH(11), .DEPTH(NODE_DEPTH)) u_offs_ram (
    .clk(clk), .we(offs_we), .waddr(offs_waddr), .wdata(offs_wdata),
    .raddr(rq.read_index), .rdata(offs_rdata)
  );

  bvhms_ram #(.WIDTH($bits(stk_rec_t)), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

endmodule

[sv/bvh_midpoint_split_build_core.sv]
// Channel   Signals                                   Handshake
// request   start, busy, request (req_t)              taken when start & !busy
// result    result_valid, result (res_t)              one cycle, no back-pressure
// config    psel, penable, pwrite, paddr, pwdata,     write when psel & penable &
//           prdata, pready                            pwrite (pready tied high)
//
// A load without last_prim is accepted with busy low, so loads stream one per
// cycle. A read holds busy in S_RD and S_RDW; its result is registered as S_RDW
// ends. A final load runs the build: an order-list entry per primitive, then per
// node S_SA-S_SC per primitive for the bounds scan and S_PA-S_PC, plus S_PD and
// S_PE for a left primitive, for the partition, paced by the order and primitive
// reads. The receiver cannot stall results. Synchronous reset; memories need none.
module bvh_midpoint_split_build_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  bvhms_pkg::req_t request,
  output logic            result_valid,
  output bvhms_pkg::res_t result,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import bvhms_pkg::*;

  logic [10:0] leaf_size;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_size <= LEAF_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      leaf_size <= pwdata[10:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {21'd0, leaf_size};

  bvhms_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  bvhms_datapath u_dp (
    .clk(clk), .rst(rst), .request(request), .leaf_size(leaf_size),
    .cmd(cmd), .sts(sts), .result_valid(result_valid), .result(result)
  );

endmodule
